@@ sv/mibt_pkg.sv @@
// Shared types and constants for the masked address ban table.
`timescale 1ns / 1ps
`default_nettype none
package mibt_pkg;

  localparam int WORD_W = 32;
  localparam int IDX_W  = 6;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_DELETE = 2'd1,
    OP_CHECK  = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_INDEX = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_WAIT,
    S_DEL_RD,
    S_DEL_WR,
    S_CHK,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic [WORD_W-1:0] addr;
    logic [WORD_W-1:0] mask;
    logic [WORD_W-1:0] expiry;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage
`default_nettype wire

@@ sv/masked_ip_ban_table.sv @@
// Top level of the masked address ban table: sequencer, entry RAM and compare unit.
`timescale 1ns / 1ps
`default_nettype none
// Ordered table of up to TABLE_DEPTH ban entries (address, mask, expiry) held in one
// RAM with a single read and a single write port. One request is worked at a time and
// in_stall is high while it runs; the next request may be taken while the previous
// result still waits on out_stall. Each request runs as a sequence of states, all bounded
// by the one RAM read port: add, or a request refused for a bad index or a full table,
// goes straight to S_FINISH; read waits in S_RD_WAIT for the registered RAM data; check
// reads every entry below entry_count (one entry compared per cycle); delete moves each
// entry above entry_index down one place (each moved entry is one read and one write).
// A result held by out_stall keeps the next result in S_FINISH until it is taken.
// Table contents are not cleared at reset; only entries below entry_count are visible.
module masked_ip_ban_table
  import mibt_pkg::*;
#(
  parameter int TABLE_DEPTH = 64
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [1:0]        in_op,
  input  wire logic [WORD_W-1:0] in_addr,
  input  wire logic [WORD_W-1:0] in_addr_mask,
  input  wire logic [WORD_W-1:0] in_expiry_time,
  input  wire logic [IDX_W-1:0]  in_entry_index,
  input  wire logic [WORD_W-1:0] in_now_time,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [1:0]             out_status,
  output logic                   out_banned,
  output logic [WORD_W-1:0]      out_entry_addr,
  output logic [WORD_W-1:0]      out_entry_mask,
  output logic [WORD_W-1:0]      out_entry_expiry
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int XW = (CW > IDX_W) ? CW : IDX_W;

  state_t            state_r, state_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [CW-1:0]     ptr_r, ptr_nxt;
  logic              pend_r, pend_nxt;
  logic              out_valid_r, out_valid_nxt;

  logic [WORD_W-1:0] key_addr_r, key_addr_nxt;
  logic [WORD_W-1:0] now_r, now_nxt;
  status_t           res_status_r, res_status_nxt;
  logic              res_banned_r, res_banned_nxt;
  entry_t            res_entry_r, res_entry_nxt;
  status_t           out_status_r, out_status_nxt;
  logic              out_banned_r, out_banned_nxt;
  entry_t            out_entry_r, out_entry_nxt;

  logic              ram_wr_en;
  logic [AW-1:0]     ram_wr_addr;
  entry_t            ram_wr_data;
  logic              ram_rd_en;
  logic [AW-1:0]     ram_rd_addr;
  entry_t            ram_rd_data;
  logic              hit;

  logic              in_take;
  op_t               op_in;
  logic              idx_ok;
  logic              full;
  logic [CW-1:0]     ptr_inc;

  assign in_stall = (state_r != S_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign op_in    = op_t'(in_op);
  assign idx_ok   = XW'(in_entry_index) < XW'(count_r);
  assign full     = (count_r == CW'(TABLE_DEPTH));
  assign ptr_inc  = ptr_r + CW'(1);

  mibt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  mibt_match u_match (
    .entry    (ram_rd_data),
    .addr     (key_addr_r),
    .now_time (now_r),
    .hit      (hit)
  );

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    ptr_nxt        = ptr_r;
    pend_nxt       = 1'b0;
    out_valid_nxt  = out_valid_r && out_stall;
    key_addr_nxt   = key_addr_r;
    now_nxt        = now_r;
    res_status_nxt = res_status_r;
    res_banned_nxt = res_banned_r;
    res_entry_nxt  = res_entry_r;
    out_status_nxt = out_status_r;
    out_banned_nxt = out_banned_r;
    out_entry_nxt  = out_entry_r;
    ram_wr_en      = 1'b0;
    ram_wr_addr    = ptr_r[AW-1:0];
    ram_wr_data    = ram_rd_data;
    ram_rd_en      = 1'b0;
    ram_rd_addr    = ptr_r[AW-1:0];

    case (state_r)
      S_IDLE: begin
        if (in_take) begin
          key_addr_nxt   = in_addr;
          now_nxt        = in_now_time;
          res_status_nxt = ST_OK;
          res_banned_nxt = 1'b0;
          res_entry_nxt  = '0;
          ptr_nxt        = CW'(in_entry_index);
          case (op_in)
            OP_ADD: begin
              if (full) begin
                res_status_nxt = ST_FULL;
              end else begin
                ram_wr_en          = 1'b1;
                ram_wr_addr        = count_r[AW-1:0];
                ram_wr_data.addr   = in_addr;
                ram_wr_data.mask   = in_addr_mask;
                ram_wr_data.expiry = in_expiry_time;
                count_nxt          = count_r + CW'(1);
              end
              state_nxt = S_FINISH;
            end
            OP_DELETE: begin
              if (idx_ok) begin
                state_nxt = S_DEL_RD;
              end else begin
                res_status_nxt = ST_BAD_INDEX;
                state_nxt      = S_FINISH;
              end
            end
            OP_CHECK: begin
              ptr_nxt   = '0;
              state_nxt = S_CHK;
            end
            OP_READ: begin
              if (idx_ok) begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = AW'(in_entry_index);
                state_nxt   = S_RD_WAIT;
              end else begin
                res_status_nxt = ST_BAD_INDEX;
                state_nxt      = S_FINISH;
              end
            end
            default: state_nxt = S_FINISH;
          endcase
        end
      end
      S_RD_WAIT: begin
        res_entry_nxt = ram_rd_data;
        state_nxt     = S_FINISH;
      end
      // move the entry above ptr down one place, then advance; with none left above, shrink the count
      S_DEL_RD: begin
        if (ptr_inc < count_r) begin
          ram_rd_en   = 1'b1;
          ram_rd_addr = ptr_inc[AW-1:0];
          state_nxt   = S_DEL_WR;
        end else begin
          count_nxt = count_r - CW'(1);
          state_nxt = S_FINISH;
        end
      end
      S_DEL_WR: begin
        ram_wr_en = 1'b1;
        ptr_nxt   = ptr_inc;
        state_nxt = S_DEL_RD;
      end
      // issue one read per cycle; compare the entry read on the previous cycle
      S_CHK: begin
        if (ptr_r < count_r) begin
          ram_rd_en = 1'b1;
          pend_nxt  = 1'b1;
          ptr_nxt   = ptr_inc;
        end
        if (pend_r && hit) begin
          res_banned_nxt = 1'b1;
        end
        if (!(ptr_r < count_r) && !pend_r) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_banned_nxt = res_banned_r;
          out_entry_nxt  = res_entry_r;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r        <= ptr_nxt;
    key_addr_r   <= key_addr_nxt;
    now_r        <= now_nxt;
    res_status_r <= res_status_nxt;
    res_banned_r <= res_banned_nxt;
    res_entry_r  <= res_entry_nxt;
    out_status_r <= out_status_nxt;
    out_banned_r <= out_banned_nxt;
    out_entry_r  <= out_entry_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_banned       = out_banned_r;
  assign out_entry_addr   = out_entry_r.addr;
  assign out_entry_mask   = out_entry_r.mask;
  assign out_entry_expiry = out_entry_r.expiry;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(TABLE_DEPTH))
    else $error("entry count above table depth");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && !$stable(count_r)) |->
      (count_r == $past(count_r) + CW'(1)) || (count_r == $past(count_r) - CW'(1)))
    else $error("entry count moved by more than one");

  a_wr_source: assert property (@(posedge clk) disable iff (!rst_n)
    ram_wr_en |-> ((state_r == S_IDLE) && (op_in == OP_ADD)) || (state_r == S_DEL_WR))
    else $error("table written outside add or delete");

  a_chk_ptr: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CHK) |-> (ptr_r <= count_r))
    else $error("check pointer ran past the table");

endmodule
`default_nettype wire

@@ sv/mibt_ram.sv @@
// Generic single write port, single read port RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module mibt_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 64,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

@@ sv/mibt_match.sv @@
// Entry compare unit: masked address match and expiry liveness test.
`timescale 1ns / 1ps
`default_nettype none
module mibt_match
  import mibt_pkg::*;
(
  input  wire entry_t            entry,
  input  wire logic [WORD_W-1:0] addr,
  input  wire logic [WORD_W-1:0] now_time,
  output logic                   hit
);

  logic addr_eq;
  logic live;

  assign addr_eq = ((addr ^ entry.addr) & entry.mask) == '0;
  // zero expiry means the ban never lapses
  assign live    = (entry.expiry == '0) || (entry.expiry >= now_time);
  assign hit     = addr_eq && live;

endmodule
`default_nettype wire

@@ bench/testbench.sv @@
// Self-checking testbench for the masked address ban table.
`timescale 1ns / 1ps
module testbench;
  import mibt_pkg::*;

  localparam int TABLE_DEPTH     = 64;
  localparam int RANDOM_REQUESTS = 1100;
  localparam int PHASE_LEN       = 150;
  localparam int DRAIN_CYCLES    = 150;
  localparam int TIMEOUT_NS      = 2_000_000;

  typedef logic [WORD_W-1:0] word_t;

  typedef enum int {PH_FILL, PH_MIX, PH_DRAIN} phase_t;
  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY} stall_mode_t;

  typedef struct packed {
    op_t              op;
    word_t            addr;
    word_t            mask;
    word_t            expiry;
    logic [IDX_W-1:0] idx;
    word_t            now;
  } ban_req_t;

  typedef struct packed {
    status_t status;
    logic    banned;
    entry_t  entry;
  } ban_res_t;

  typedef struct packed {
    ban_req_t req;
    logic     typed;
    ban_res_t res;
  } dir_row_t;

  logic             clk            = 1'b0;
  logic             rst_n          = 1'b0;
  logic             in_valid       = 1'b0;
  logic             in_stall;
  logic [1:0]       in_op          = '0;
  word_t            in_addr        = '0;
  word_t            in_addr_mask   = '0;
  word_t            in_expiry_time = '0;
  logic [IDX_W-1:0] in_entry_index = '0;
  word_t            in_now_time    = '0;
  logic             out_valid;
  logic             out_stall      = 1'b0;
  logic [1:0]       out_status;
  logic             out_banned;
  word_t            out_entry_addr;
  word_t            out_entry_mask;
  word_t            out_entry_expiry;

  // shadow copy of the table
  entry_t      shadow_entries [TABLE_DEPTH];
  int unsigned shadow_count = 0;

  ban_res_t    pending_results [$];
  int          failures     = 0;
  int          checked      = 0;
  int          issued       = 0;
  int          refused_full = 0;
  int          bad_indexes  = 0;
  int          banned_hits  = 0;
  int          burst_left   = 0;
  stall_mode_t stall_mode   = STALL_NONE;
  int          stall_left   = 0;

  masked_ip_ban_table #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_op           (in_op),
    .in_addr         (in_addr),
    .in_addr_mask    (in_addr_mask),
    .in_expiry_time  (in_expiry_time),
    .in_entry_index  (in_entry_index),
    .in_now_time     (in_now_time),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_banned      (out_banned),
    .out_entry_addr  (out_entry_addr),
    .out_entry_mask  (out_entry_mask),
    .out_entry_expiry(out_entry_expiry)
  );

  always #1 clk = ~clk;

  // Applies one request to the shadow table and returns the answer it should get.
  function automatic ban_res_t ban_table_apply(ban_req_t r);
    ban_res_t    res;
    entry_t      e;
    int unsigned i;
    res = '0;
    case (r.op)
      OP_ADD: begin
        if (shadow_count >= TABLE_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          e.addr   = r.addr;
          e.mask   = r.mask;
          e.expiry = r.expiry;
          shadow_entries[shadow_count] = e;
          shadow_count++;
        end
      end
      OP_DELETE: begin
        if (r.idx >= shadow_count) begin
          res.status = ST_BAD_INDEX;
        end else begin
          for (i = 32'(r.idx); i + 1 < shadow_count; i++)
            shadow_entries[i] = shadow_entries[i + 1];
          shadow_count--;
        end
      end
      OP_CHECK: begin
        for (i = 0; i < shadow_count; i++) begin
          e = shadow_entries[i];
          if ((r.addr & e.mask) == (e.addr & e.mask) && (e.expiry == 0 || e.expiry >= r.now))
            res.banned = 1'b1;
        end
      end
      default: begin
        if (r.idx >= shadow_count) res.status = ST_BAD_INDEX;
        else res.entry = shadow_entries[r.idx];
      end
    endcase
    return res;
  endfunction

  function automatic dir_row_t dir_row(op_t op, word_t a, word_t m, word_t ex,
                                       logic [IDX_W-1:0] idx, word_t now,
                                       logic typed = 1'b0, status_t st = ST_OK,
                                       logic bn = 1'b0, entry_t ent = '0);
    dir_row_t row;
    row.req.op     = op;
    row.req.addr   = a;
    row.req.mask   = m;
    row.req.expiry = ex;
    row.req.idx    = idx;
    row.req.now    = now;
    row.typed      = typed;
    row.res.status = st;
    row.res.banned = bn;
    row.res.entry  = ent;
    return row;
  endfunction

  // Random request; mostly aimed at stored entries so checks and reads hit.
  function automatic ban_req_t random_request(phase_t ph);
    ban_req_t r;
    entry_t   e;
    int       pick;
    int       k;
    r.addr   = $urandom;
    r.mask   = $urandom;
    r.expiry = $urandom;
    r.idx    = IDX_W'($urandom);
    r.now    = $urandom;
    pick     = $urandom_range(0, 99);
    case (ph)
      PH_FILL:  r.op = pick < 70 ? OP_ADD : pick < 85 ? OP_CHECK : pick < 95 ? OP_READ : OP_DELETE;
      PH_DRAIN: r.op = pick < 55 ? OP_DELETE : pick < 75 ? OP_CHECK : pick < 90 ? OP_READ : OP_ADD;
      default:  r.op = pick < 25 ? OP_ADD : pick < 50 ? OP_DELETE : pick < 75 ? OP_CHECK : OP_READ;
    endcase
    case (r.op)
      OP_ADD: begin
        if ($urandom_range(0, 9) < 7)
          r.mask = ~(32'hFFFF_FFFF >> $urandom_range(0, 32));
        case ($urandom_range(0, 3))
          0:       r.expiry = '0;
          1:       r.expiry = $urandom_range(0, 1000);
          default: ;
        endcase
      end
      OP_CHECK: begin
        if (shadow_count > 0 && $urandom_range(0, 9) < 7) begin
          k = $urandom_range(0, shadow_count - 1);
          e = shadow_entries[k];
          r.addr = (e.addr & e.mask) | (r.addr & ~e.mask);
          if ($urandom_range(0, 4) == 0) r.addr ^= 32'h1 << $urandom_range(0, 31);
          case ($urandom_range(0, 3))
            0:       r.now = e.expiry;
            1:       r.now = e.expiry + 1;
            2:       r.now = $urandom_range(0, 1000);
            default: ;
          endcase
        end
      end
      default: begin
        if (shadow_count > 0 && $urandom_range(0, 9) < 8)
          r.idx = IDX_W'($urandom_range(0, shadow_count - 1));
      end
    endcase
    return r;
  endfunction

  // Sends one request in a burst/gap pattern and books its expected answer on accept.
  task automatic issue_request(ban_req_t r, logic typed, ban_res_t typed_res);
    int       gap;
    ban_res_t answer;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
    end
    @(negedge clk);
    in_valid       <= 1'b1;
    in_op          <= r.op;
    in_addr        <= r.addr;
    in_addr_mask   <= r.mask;
    in_expiry_time <= r.expiry;
    in_entry_index <= r.idx;
    in_now_time    <= r.now;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    answer = ban_table_apply(r);
    if (typed) answer = typed_res;
    pending_results.push_back(answer);
    issued++;
    if (answer.status == ST_FULL) refused_full++;
    if (answer.status == ST_BAD_INDEX) bad_indexes++;
    if (answer.banned) banned_hits++;
    burst_left--;
  endtask

  task automatic check_field(string name, word_t expd, word_t got);
    if (got !== expd) begin
      $error("%s: expected %0h, got %0h", name, expd, got);
      failures++;
    end
  endtask

  always @(posedge clk) begin : result_monitor
    ban_res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: status %0d banned %0d", out_status, out_banned);
        failures++;
      end else begin
        want = pending_results.pop_front();
        checked++;
        check_field("status", want.status, out_status);
        check_field("banned", want.banned, out_banned);
        check_field("entry_addr", want.entry.addr, out_entry_addr);
        check_field("entry_mask", want.entry.mask, out_entry_mask);
        check_field("entry_expiry", want.entry.expiry, out_entry_expiry);
      end
    end
  end

  // result side back-pressure: none, light or heavy stall modes, picked at random
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 2));
      stall_left = $urandom_range(20, 200);
    end
    stall_left--;
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      default:     out_stall <= ($urandom_range(0, 3) != 0);
    endcase
  end

  initial begin : stimulus
    dir_row_t directed [$];
    phase_t   ph;
    int       n;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    directed.push_back(dir_row(OP_READ, '1, '1, '1, 6'd63, '1, 1'b1, ST_BAD_INDEX));
    directed.push_back(dir_row(OP_DELETE, '0, '0, '0, 6'd0, '0, 1'b1, ST_BAD_INDEX));
    directed.push_back(dir_row(OP_CHECK, '0, '0, '0, 6'd0, '0, 1'b1, ST_OK, 1'b0));
    directed.push_back(dir_row(OP_ADD, '1, '1, '0, 6'd63, '1, 1'b1, ST_OK));
    directed.push_back(dir_row(OP_READ, '0, '0, '0, 6'd0, '0, 1'b1, ST_OK, 1'b0,
                               {32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0}));
    // never-expiring entry stays live at the latest time
    directed.push_back(dir_row(OP_CHECK, '1, '0, '0, 6'd0, '1, 1'b1, ST_OK, 1'b1));
    directed.push_back(dir_row(OP_CHECK, 32'hFFFF_FFFE, '1, '1, 6'd63, '0, 1'b1, ST_OK, 1'b0));
    directed.push_back(dir_row(OP_ADD, 32'h0A00_0000, 32'hFF00_0000, 32'd100, 6'd0, '0));
    // expiry equal to now is still live, one past is not
    directed.push_back(dir_row(OP_CHECK, 32'h0A12_3456, '0, '0, 6'd0, 32'd100));
    directed.push_back(dir_row(OP_CHECK, 32'h0A12_3456, '0, '0, 6'd0, 32'd101));
    directed.push_back(dir_row(OP_ADD, '0, '0, '1, 6'd0, '0));
    directed.push_back(dir_row(OP_CHECK, 32'h1234_5678, '0, '0, 6'd0, '1));
    directed.push_back(dir_row(OP_READ, '0, '0, '0, 6'd2, '0));
    directed.push_back(dir_row(OP_READ, '0, '0, '0, 6'd3, '0, 1'b1, ST_BAD_INDEX));
    directed.push_back(dir_row(OP_DELETE, '1, '1, '1, 6'd0, '1));
    directed.push_back(dir_row(OP_READ, '0, '0, '0, 6'd0, '0));
    directed.push_back(dir_row(OP_DELETE, '0, '0, '0, 6'd1, '0));
    directed.push_back(dir_row(OP_DELETE, '0, '0, '0, 6'd1, '0, 1'b1, ST_BAD_INDEX));
    directed.push_back(dir_row(OP_CHECK, 32'hC0A8_0001, '0, '0, 6'd0, 32'd5));
    directed.push_back(dir_row(OP_DELETE, '0, '0, '0, 6'd0, '0, 1'b1, ST_OK));
    directed.push_back(dir_row(OP_CHECK, 32'h0A00_0001, '0, '0, 6'd0, '0, 1'b1, ST_OK, 1'b0));

    foreach (directed[i])
      issue_request(directed[i].req, directed[i].typed, directed[i].res);

    // fill / mix / drain rounds so the table hits both full and empty
    for (n = 0; n < RANDOM_REQUESTS; n++) begin
      case ((n / PHASE_LEN) % 4)
        0:       ph = PH_FILL;
        2:       ph = PH_DRAIN;
        default: ph = PH_MIX;
      endcase
      issue_request(random_request(ph), 1'b0, '0);
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d requests (%0d directed), checked %0d results.",
             issued, directed.size(), checked);
    $display("Adds refused on a full table: %0d, bad indexes: %0d, checks banned: %0d.",
             refused_full, bad_indexes, banned_hits);
    if (failures == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #TIMEOUT_NS;
    $display("timeout: %0d results still pending", pending_results.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

@@ files.f @@
sv/mibt_pkg.sv
sv/mibt_ram.sv
sv/mibt_match.sv
sv/masked_ip_ban_table.sv
bench/testbench.sv
